[rtl/mck_pkg.sv]
`timescale 1ns / 1ps
package mck_pkg;

	localparam int unsigned ToneW = 12;
	localparam int unsigned CodeW = 8;
	localparam int unsigned PhaseW = 5;

	localparam logic [PhaseW-1:0] PH_START  = 5'd0;
	localparam logic [PhaseW-1:0] PH_DASH   = 5'd7;
	localparam logic [PhaseW-1:0] PH_DIT    = 5'd9;
	localparam logic [PhaseW-1:0] PH_STOP   = 5'd10;
	localparam logic [PhaseW-1:0] PH_SPACE  = 5'd15;
	localparam logic [PhaseW-1:0] PH_CHRGAP = 5'd19;
	localparam logic [PhaseW-1:0] PH_FETCH  = 5'd20;

	localparam logic [ToneW-1:0] TONE_RESET = 12'd2100;
	localparam logic [CodeW-1:0] CODE_SPACE = 8'h00;
	localparam logic [CodeW-1:0] CODE_END   = 8'h01;

	localparam logic [7:0] CHAR_FIRST = 8'h2C;
	localparam logic [7:0] CHAR_LAST  = 8'h5A;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef logic [CodeW-1:0] code_t;

	// symbol codes for ',' through 'Z', read from bit 0, a remaining 1 ends the char
	function automatic code_t code_rom(input logic [5:0] idx);
		code_t c;
		unique case (idx)
			6'd0:  c = 8'h73;
			6'd2:  c = 8'h6a;
			6'd3:  c = 8'h29;
			6'd4:  c = 8'h3f;
			6'd5:  c = 8'h3e;
			6'd6:  c = 8'h3c;
			6'd7:  c = 8'h38;
			6'd8:  c = 8'h30;
			6'd9:  c = 8'h20;
			6'd10: c = 8'h21;
			6'd11: c = 8'h23;
			6'd12: c = 8'h27;
			6'd13: c = 8'h2f;
			6'd19: c = 8'h4c;
			6'd21: c = 8'h06;
			6'd22: c = 8'h11;
			6'd23: c = 8'h15;
			6'd24: c = 8'h09;
			6'd25: c = 8'h02;
			6'd26: c = 8'h14;
			6'd27: c = 8'h0b;
			6'd28: c = 8'h10;
			6'd29: c = 8'h04;
			6'd30: c = 8'h1e;
			6'd31: c = 8'h0d;
			6'd32: c = 8'h12;
			6'd33: c = 8'h07;
			6'd34: c = 8'h05;
			6'd35: c = 8'h0f;
			6'd36: c = 8'h16;
			6'd37: c = 8'h1b;
			6'd38: c = 8'h0a;
			6'd39: c = 8'h08;
			6'd40: c = 8'h03;
			6'd41: c = 8'h0c;
			6'd42: c = 8'h18;
			6'd43: c = 8'h0e;
			6'd44: c = 8'h19;
			6'd45: c = 8'h1d;
			6'd46: c = 8'h13;
			default: c = CODE_SPACE;
		endcase
		return c;
	endfunction

	function automatic code_t encode_char(input logic [7:0] ch);
		logic [7:0] u;
		logic [7:0] off;
		u = ch;
		if (ch >= LOWER_A && ch <= LOWER_Z) begin
			u = ch - CASE_DIFF;
		end
		off = u - CHAR_FIRST;
		if (u < CHAR_FIRST || u > CHAR_LAST) begin
			return CODE_SPACE;
		end
		return code_rom(off[5:0]);
	endfunction

endpackage

[rtl/morse_code_keyer.sv]
`timescale 1ns / 1ps
// morse code keyer, one beat on the input channel per timer tick
// s_axis: tuser = char_valid, tdata[7:0] = char_byte; with tuser low the
//   tick only advances timing, and in the fetch phase reports finished
// m_axis: one result beat per input beat; tdata[0] = key_on,
//   tdata[12:1] = tone_out, tuser[0] = char_taken, tuser[1] = finished
// cfg_wr_en / cfg_wr_data set tone_code, write it only while idle
// latency: the result beat is valid the cycle after its input beat
// throughput: one tick per cycle unless stalled; the phase/code update and
//   the code table lookup sit in front of the state and result registers
// stall: s_axis_tready drops only while a result is held and m_axis_tready
//   is low; the result register holds its beat until taken
// reset: phase goes to the fetch phase, key off, code zero, tone_code 2100,
//   result register empty; the first tick fetches the first character
module morse_code_keyer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // char_byte
	input  logic                      s_axis_tuser,  // char_valid
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // key_on, tone_out, zero pad
	output logic [1:0]                m_axis_tuser,  // char_taken, finished
	input  logic                      cfg_wr_en,
	input  logic [mck_pkg::ToneW-1:0] cfg_wr_data
);
	import mck_pkg::*;

	logic [PhaseW-1:0] phase_q, phase_d;
	code_t             code_q, code_d;
	logic              key_q, key_d;
	logic [ToneW-1:0]  tone_q;
	logic              taken_d, fin_d;
	logic              accept;

	logic              out_valid_q;
	logic              key_on_q;
	logic [ToneW-1:0]  tone_out_q;
	logic              taken_q, fin_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		phase_d = phase_q;
		code_d = code_q;
		key_d = key_q;
		taken_d = 1'b0;
		fin_d = 1'b0;
		priority if (phase_q == PH_START) begin
			if (code_q == CODE_SPACE) begin
				phase_d = PH_SPACE;
			end else if (code_q == CODE_END) begin
				phase_d = PH_CHRGAP;
			end else begin
				key_d = 1'b1;
				phase_d = code_q[0] ? PH_DASH : PH_DIT;
				code_d = code_q >> 1;
			end
		end else if (phase_q == PH_STOP) begin
			key_d = 1'b0;
			phase_d = PH_START;
		end else if (phase_q == PH_FETCH) begin
			if (!s_axis_tuser) begin
				fin_d = 1'b1;
			end else begin
				code_d = encode_char(s_axis_tdata);
				phase_d = PH_START;
				taken_d = 1'b1;
			end
		end else begin
			phase_d = phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FETCH;
			code_q <= CODE_SPACE;
			key_q <= 1'b0;
			tone_q <= TONE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tone_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q <= phase_d;
				code_q <= code_d;
				key_q <= key_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_on_q <= key_d;
			tone_out_q <= key_d ? tone_q : '0;
			taken_q <= taken_d;
			fin_q <= fin_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, tone_out_q, key_on_q};
	assign m_axis_tuser = {fin_q, taken_q};

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_FETCH)
		else $error("phase out of range");

	a_key_phase: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |-> (phase_q >= PH_DASH && phase_q <= PH_STOP))
		else $error("key on outside an element");

	a_fin_key_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tdata[0])
		else $error("finished while key on");

	a_taken_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("taken and finished together");

	a_fetch_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_FETCH && !s_axis_tuser) |=> phase_q == PH_FETCH)
		else $error("left fetch without a character");

endmodule

[dv/mck_checker.sv]
`timescale 1ns / 1ps
module mck_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,
	input  logic                      s_axis_tuser,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [15:0]               m_axis_tdata,
	input  logic [1:0]                m_axis_tuser,
	input  logic                      cfg_wr_en,
	input  logic [mck_pkg::ToneW-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        pending
);
	import mck_pkg::*;

	typedef struct packed {
		logic             key_on;
		logic [ToneW-1:0] tone_out;
		logic             char_taken;
		logic             finished;
	} tick_result_t;

	// symbols for ',' through 'Z'
	localparam logic [CodeW-1:0] MORSE_TABLE [47] = '{
		8'h73, 8'h00, 8'h6a, 8'h29, 8'h3f, 8'h3e, 8'h3c, 8'h38,
		8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2f, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h4c, 8'h00, 8'h06, 8'h11, 8'h15,
		8'h09, 8'h02, 8'h14, 8'h0b, 8'h10, 8'h04, 8'h1e, 8'h0d,
		8'h12, 8'h07, 8'h05, 8'h0f, 8'h16, 8'h1b, 8'h0a, 8'h08,
		8'h03, 8'h0c, 8'h18, 8'h0e, 8'h19, 8'h1d, 8'h13
	};

	tick_result_t     expected_beats [$];
	logic [ToneW-1:0] tone;
	logic [CodeW-1:0] symbol;
	logic [PhaseW-1:0] step;
	logic             keyed;

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [CodeW-1:0] symbol_for(input logic [7:0] ch);
		logic [7:0] up;
		up = ch;
		if (ch >= LOWER_A && ch <= LOWER_Z) begin
			up = ch - CASE_DIFF;
		end
		if (up < CHAR_FIRST || up > CHAR_LAST) begin
			return CODE_SPACE;
		end
		return MORSE_TABLE[up - CHAR_FIRST];
	endfunction

	function automatic tick_result_t advance_keyer(input logic avail, input logic [7:0] ch);
		tick_result_t r;
		r = '0;
		case (step)
			PH_START: begin
				if (symbol == CODE_SPACE) begin
					step = PH_SPACE;
				end else if (symbol == CODE_END) begin
					step = PH_CHRGAP;
				end else begin
					keyed = 1'b1;
					step = symbol[0] ? PH_DASH : PH_DIT;
					symbol = symbol >> 1;
				end
			end
			PH_STOP: begin
				keyed = 1'b0;
				step = PH_START;
			end
			PH_FETCH: begin
				if (!avail) begin
					r.finished = 1'b1;
				end else begin
					symbol = symbol_for(ch);
					step = PH_START;
					r.char_taken = 1'b1;
				end
			end
			default: begin
				step = step + 1'b1;
			end
		endcase
		r.key_on = keyed;
		r.tone_out = keyed ? tone : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			tone = TONE_RESET;
			symbol = '0;
			step = PH_FETCH;
			keyed = 1'b0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.key_on = m_axis_tdata[0];
				got.tone_out = m_axis_tdata[ToneW:1];
				got.char_taken = m_axis_tuser[0];
				got.finished = m_axis_tuser[1];
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					if (got.key_on !== want.key_on)
						report_mismatch($sformatf("key_on got %b want %b",
							got.key_on, want.key_on));
					if (got.tone_out !== want.tone_out)
						report_mismatch($sformatf("tone_out got %0d want %0d",
							got.tone_out, want.tone_out));
					if (got.char_taken !== want.char_taken)
						report_mismatch($sformatf("char_taken got %b want %b",
							got.char_taken, want.char_taken));
					if (got.finished !== want.finished)
						report_mismatch($sformatf("finished got %b want %b",
							got.finished, want.finished));
				end
			end
			if (cfg_wr_en) begin
				tone = cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_beats.push_back(advance_keyer(s_axis_tuser, s_axis_tdata));
			end
			pending <= expected_beats.size();
		end
	end

endmodule

[dv/tb_morse_code_keyer.sv]
`timescale 1ns / 1ps
module tb_morse_code_keyer;
	import mck_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomTicks = 500;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;
	logic             s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [15:0]      m_axis_tdata;
	logic [1:0]       m_axis_tuser;
	logic             cfg_wr_en;
	logic [ToneW-1:0] cfg_wr_data;
	int               fail_count;
	int               pending;
	int               send_idle_pct;
	int               recv_stall_pct;
	int               cycle_count = 0;

	// {char_valid, char_byte} per tick, laid out against the fetch points
	localparam logic [8:0] DIRECTED_TICKS [25] = '{
		{1'b0, 8'hFF}, {1'b1, 8'h65}, {1'b1, 8'h00}, {1'b0, 8'hAA}, {1'b1, 8'h55},
		{1'b0, 8'h00}, {1'b1, 8'hFF}, {1'b0, 8'h3C}, {1'b1, 8'h7B}, {1'b1, 8'h2B},
		{1'b1, 8'h2B}, {1'b0, 8'hC3}, {1'b1, 8'h5B}, {1'b1, 8'h60}, {1'b0, 8'h7F},
		{1'b1, CHAR_FIRST}, {1'b1, CHAR_LAST}, {1'b1, LOWER_Z}, {1'b1, 8'h5B},
		{1'b1, 8'h60}, {1'b1, 8'h2B}, {1'b1, LOWER_A}, {1'b0, 8'h80},
		{1'b1, 8'h01}, {1'b1, 8'h7F}
	};

	localparam logic [7:0] EDGE_CHARS [10] = '{
		CHAR_FIRST, CHAR_LAST, 8'h2B, 8'h5B, LOWER_A, LOWER_Z, 8'h60, 8'h7B, 8'h00, 8'hFF
	};

	morse_code_keyer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	mck_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_tick(input logic avail, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= avail;
		s_axis_tdata <= ch;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tone(input logic [ToneW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60) return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
		if (roll < 80) return 8'($urandom_range(LOWER_A, LOWER_Z));
		if (roll < 90) return EDGE_CHARS[$urandom_range(9)];
		return 8'($urandom_range(255));
	endfunction

	task automatic run_random_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			send_tick($urandom_range(99) < 85, pick_char());
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle_pct = 28;
		recv_stall_pct = 73;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tone value first
		foreach (DIRECTED_TICKS[i]) begin
			send_tick(DIRECTED_TICKS[i][8], DIRECTED_TICKS[i][7:0]);
		end
		drain_results();

		write_tone('1);
		run_random_ticks(RandomTicks);

		send_idle_pct = 73;
		recv_stall_pct = 28;
		write_tone('0);
		run_random_ticks(RandomTicks);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_tone(ToneW'($urandom_range(4095)));
		run_random_ticks(RandomTicks);

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/mck_pkg.sv
rtl/morse_code_keyer.sv
dv/mck_checker.sv
dv/tb_morse_code_keyer.sv
